>>> hdl/bsst_pkg.sv
package bsst_pkg;

  localparam int BSST_CAPACITY = 64;
  localparam int LIMIT_W       = 7;
  localparam int VALUE_W       = 32;
  localparam int SPAN_W        = 32;
  localparam int STATUS_W      = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REJECT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic                      action;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LIMIT_W-1:0]  element_count;
    logic                spans_valid;
    logic [SPAN_W-1:0]   shortest_span;
    logic [SPAN_W-1:0]   longest_span;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    op_t  op;
    logic capture;
    logic prep;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic full;
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
  } sts_t;

endpackage

>>> hdl/bsst_ctrl.sv
module bsst_ctrl
  import bsst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_WAIT
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   busy_r;
  op_t    op_dec;

  always_comb begin
    if (sts.is_clear) begin
      op_dec = OP_CLEAR;
    end else if (sts.full) begin
      op_dec = OP_REJECT;
    end else begin
      op_dec = OP_INSERT;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = op_r;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_DECIDE: begin
        cmd.op   = op_dec;
        cmd.prep = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_WAIT: begin
        cmd.commit = !sts.pipe_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_INSERT;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DECIDE;
            busy_r  <= 1'b1;
          end
        end
        S_DECIDE: begin
          op_r <= op_dec;
          if (op_dec == OP_INSERT && !sts.count_zero) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!sts.pipe_busy) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;

endmodule

>>> hdl/bsst_dp.sv
module bsst_dp
  import bsst_pkg::*;
#(
  parameter int CAPACITY = BSST_CAPACITY
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  in_item_t           in_item,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  output out_item_t          out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // element storage, unsorted; only slots below count_r are read
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata_r;

  in_item_t           item_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   count_r;
  logic [VALUE_W-1:0] min_r, max_r;
  logic [SPAN_W-1:0]  gap_r;
  logic [VALUE_W-1:0] cand_min_r, cand_max_r;
  logic [SPAN_W-1:0]  acc_r;
  logic [SPAN_W-1:0]  abs_r;
  logic [AW-1:0]      idx_r;
  logic               rd_v_r, abs_v_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [CMP_W-1:0]   cnt_cmp, lim_cmp, lim_eff;
  logic [VALUE_W:0]   d_vx, d_xv;
  logic [SPAN_W-1:0]  abs_d;
  logic               v_lt_min, v_gt_max;
  logic [CNT_W-1:0]   cnt_res;
  logic               valid_res;
  logic [VALUE_W-1:0] span_res;

  // effective limit: register clipped to storage depth
  always_comb begin
    cnt_cmp = CMP_W'(count_r);
    lim_cmp = CMP_W'(limit_r);
    lim_eff = (lim_cmp > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : lim_cmp;
  end

  assign sts.is_clear   = item_r.action;
  assign sts.full       = (cnt_cmp >= lim_eff);
  assign sts.count_zero = (count_r == '0);
  assign sts.scan_last  = (CNT_W'(idx_r) == count_r - CNT_W'(1));
  assign sts.pipe_busy  = rd_v_r | abs_v_r;

  // distance of the new value to one stored element, 33-bit exact
  always_comb begin
    d_vx  = {item_r.value[VALUE_W-1], item_r.value} - {rdata_r[VALUE_W-1], rdata_r};
    d_xv  = {rdata_r[VALUE_W-1], rdata_r} - {item_r.value[VALUE_W-1], item_r.value};
    abs_d = d_vx[VALUE_W] ? d_xv[SPAN_W-1:0] : d_vx[SPAN_W-1:0];
  end

  assign v_lt_min = (item_r.value < $signed(min_r));
  assign v_gt_max = (item_r.value > $signed(max_r));

  always_ff @(posedge clk) begin
    if (cmd.prep && cmd.op == OP_INSERT) begin
      mem[count_r[AW-1:0]] <= item_r.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // scan pipeline: read, distance, running minimum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      abs_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.scan;
      abs_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + AW'(1);
    end
    if (rd_v_r) begin
      abs_r <= abs_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
      acc_r  <= (count_r >= CNT_W'(2)) ? gap_r : '1;
    end else if (abs_v_r && abs_r < acc_r) begin
      acc_r <= abs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (cmd.op == OP_INSERT) begin
        cand_min_r <= (sts.count_zero || v_lt_min) ? item_r.value : min_r;
        cand_max_r <= (sts.count_zero || v_gt_max) ? item_r.value : max_r;
      end else begin
        cand_min_r <= min_r;
        cand_max_r <= max_r;
      end
    end
  end

  always_comb begin
    case (cmd.op)
      OP_CLEAR:  cnt_res = '0;
      OP_INSERT: cnt_res = count_r + CNT_W'(1);
      default:   cnt_res = count_r;
    endcase
    valid_res = (cnt_res >= CNT_W'(2));
    span_res  = cand_max_r - cand_min_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        count_r <= cnt_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (cmd.op == OP_INSERT) begin
        min_r <= cand_min_r;
        max_r <= cand_max_r;
        gap_r <= acc_r;
      end
      case (cmd.op)
        OP_CLEAR:  out_r.status <= ST_CLEARED;
        OP_REJECT: out_r.status <= ST_FULL;
        default:   out_r.status <= ST_INSERTED;
      endcase
      out_r.element_count <= LIMIT_W'(cnt_res);
      out_r.spans_valid   <= valid_res;
      out_r.shortest_span <= valid_res ? acc_r : '0;
      out_r.longest_span  <= valid_res ? span_res : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> hdl/bounded_set_span_tracker.sv
// Bounded set span tracker. Holds up to min(element_limit, CAPACITY) signed
// 32-bit values (duplicates kept). Pulse start while busy is low to hand in an
// item: action 0 adds in_item.value, action 1 empties the set. Each item gives
// exactly one result on out_item, shown for a single cycle with out_valid high;
// the receiver cannot stall it, so it must take the result in that cycle. A
// clear, a rejected add (set full) or an add to an empty set holds busy only
// through the decide and wait states. An add to a set of n >= 1 elements also
// scans: the new value is compared against every stored element, one memory
// read per cycle, to find its nearest neighbour. The result appears in the
// first cycle busy is low again, and a new item may start in that same cycle.
// The user must write element_limit through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce it. element_limit resets to 64.
module bounded_set_span_tracker
  import bsst_pkg::*;
#(
  parameter int CAPACITY = BSST_CAPACITY
)
(
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  // result output
  output logic               out_valid,
  output out_item_t          out_item,
  // element_limit register
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  // Shortest span is kept incrementally: inserting v between neighbours a
  // and b replaces gap b-a with v-a and b-v, both no larger, so the new
  // minimum is min(old minimum, distance from v to its nearest element).
  // Longest span comes from running min/max registers.

  cmd_t cmd;
  sts_t sts;

  bsst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bsst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hdl/bsst_chk.sv
module bsst_chk
  import bsst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // an accepted item holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // result shows only once the block is idle again, one cycle wide
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy ##1 !out_valid))
    else $error("result while busy or held too long");

  a_spans_need_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.spans_valid) |-> (out_item.element_count >= 7'd2))
    else $error("spans valid with fewer than two elements");

  a_spans_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.spans_valid) |->
      (out_item.shortest_span == '0 && out_item.longest_span == '0))
    else $error("spans not zero when invalid");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_CLEARED) |-> (out_item.element_count == '0))
    else $error("clear left elements");

endmodule

bind bounded_set_span_tracker bsst_chk u_bsst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

>>> verif/tb_bounded_set_span_tracker.sv
`timescale 1ns / 1ps

module tb_bounded_set_span_tracker;
  import bsst_pkg::*;

  // item action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // watchdog, far above the slowest legal run (~1800 items)
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 140;
  // drain wait: covers the longest add (one slot left)
  localparam int DRAIN_CYCLES = BSST_CAPACITY + 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_item_t           in_item = '0;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  bounded_set_span_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the block's state: sorted contents and the limit last written.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] set_mirror[$];
  int unsigned               limit_mirror = LIMIT_RESET;

  in_item_t  pending_items[$];   // items waiting for the driver
  out_item_t results_due[$];     // predicted results, oldest first

  int idle_pct = 0;              // chance (percent) of a gap after an item
  int idle_left = 0;
  logic [31:0] cluster_base = '0;

  int cycles = 0;
  int mismatches = 0;
  int items_taken = 0;
  int results_seen = 0;
  int n_inserted = 0;
  int n_full = 0;
  int n_cleared = 0;
  int peak_count = 0;
  out_item_t due_head;

  // exact difference of two signed 32-bit values; always fits 32 unsigned bits
  function automatic logic [SPAN_W-1:0] span_between(logic signed [VALUE_W-1:0] hi,
                                                     logic signed [VALUE_W-1:0] lo);
    logic [VALUE_W:0] d;
    d = {hi[VALUE_W-1], hi} - {lo[VALUE_W-1], lo};
    return d[SPAN_W-1:0];
  endfunction

  // Applies one accepted item to the mirror and returns the result it causes.
  function automatic out_item_t predict_span(in_item_t it);
    out_item_t                 r;
    int unsigned               eff_limit;
    int                        pos;
    logic signed [VALUE_W-1:0] v;
    logic [SPAN_W-1:0]         d;
    r = '0;
    v = $signed(it.value);
    // limits above capacity behave as capacity
    eff_limit = (limit_mirror > BSST_CAPACITY) ? BSST_CAPACITY : limit_mirror;
    if (it.action == ACT_CLEAR) begin
      set_mirror.delete();
      r.status = ST_CLEARED;
    end else if (set_mirror.size() >= eff_limit) begin
      // full, or limit lowered under the count: nothing changes
      r.status = ST_FULL;
    end else begin
      pos = 0;
      while (pos < set_mirror.size() && set_mirror[pos] <= v) pos++;
      set_mirror.insert(pos, v);
      r.status = ST_INSERTED;
    end
    r.element_count = LIMIT_W'(set_mirror.size());
    // fewer than two elements: spans stay zero
    if (set_mirror.size() >= 2) begin
      r.spans_valid   = 1'b1;
      r.shortest_span = '1;
      for (int k = 1; k < set_mirror.size(); k++) begin
        d = span_between(set_mirror[k], set_mirror[k-1]);
        if (d < r.shortest_span) r.shortest_span = d;
      end
      r.longest_span = span_between(set_mirror[set_mirror.size()-1], set_mirror[0]);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items; start stays up until the block takes one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        results_due.insert(results_due.size(), predict_span(in_item));
        items_taken++;
      end
      // an item still waiting on busy keeps start and in_item as they are
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          start   <= 1'b1;
          if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
            idle_left = $urandom_range(1, 7);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result must match the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        mismatches++;
      end else begin
        due_head = results_due.pop_front();
        check_field("status", 32'(due_head.status), 32'(out_item.status));
        check_field("element_count", 32'(due_head.element_count),
                    32'(out_item.element_count));
        check_field("spans_valid", 32'(due_head.spans_valid), 32'(out_item.spans_valid));
        check_field("shortest_span", due_head.shortest_span, out_item.shortest_span);
        check_field("longest_span", due_head.longest_span, out_item.longest_span);
        case (due_head.status)
          ST_INSERTED: n_inserted++;
          ST_FULL:     n_full++;
          default:     n_cleared++;
        endcase
        if (int'(due_head.element_count) > peak_count)
          peak_count = int'(due_head.element_count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d items taken, %0d results outstanding",
               $time, items_taken, results_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_add(logic [VALUE_W-1:0] v);
    in_item_t it;
    it.action = ACT_ADD;
    it.value  = v;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_clear(logic [VALUE_W-1:0] v);
    in_item_t it;
    it.action = ACT_CLEAR;
    it.value  = v;      // ignored by the block
    pending_items.insert(pending_items.size(), it);
  endtask

  // all queued items taken and all results back; the block is then idle
  task automatic wait_drained();
    while (pending_items.size() > 0 || start || idle_left > 0 || results_due.size() > 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write, only ever issued while drained
  task automatic write_limit(int unsigned v);
    @(posedge clk);
    cfg_wdata <= v[LIMIT_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_mirror = v[LIMIT_W-1:0];
  endtask

  // mix of wide-open values, near-duplicates and values near the extremes
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 40) - 20;
      1:       return 32'h7FFF_FFFF - $urandom_range(0, 8);
      2:       return 32'h8000_0000 + $urandom_range(0, 8);
      3:       return cluster_base + $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  int phase_limit[RAND_PHASES] = '{64, 127, 1, 2, 7, 0, 65, 16, 64, -1, -1, 64};
  int clear_pct;
  int lim;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset limit of 64 ---
    queue_clear('0);                  // clear of an empty set
    queue_add(32'h0000_0000);         // single element, no spans
    queue_add(32'h0000_0000);         // duplicate, gap 0
    queue_add(32'h7FFF_FFFF);
    queue_add(32'h8000_0000);         // span covers the whole range
    queue_clear('1);
    queue_add(32'h8000_0000);
    queue_add(32'h7FFF_FFFF);         // only gap is the full range
    queue_add(32'hFFFF_FFFF);
    queue_add(32'h0000_0001);
    queue_add(32'h0000_0005);
    queue_clear(32'h5A5A_A5A5);
    wait_drained();

    // zero limit: every add rejected
    write_limit(0);
    queue_add(32'h1234_5678);
    queue_add(32'h8000_0000);
    queue_clear('0);
    wait_drained();

    // small limit fills, then rejects
    write_limit(3);
    queue_add(32'd10);
    queue_add(32'hFFFF_FFF6);
    queue_add(32'd3);
    queue_add(32'd4);
    wait_drained();

    // limit lowered below the count: rejects, nothing dropped
    write_limit(2);
    queue_add(32'd7);
    queue_clear('0);
    queue_add(32'd1);
    queue_add(32'd1);
    queue_add(32'd2);
    wait_drained();

    // --- random phases over a spread of limits, extremes included ---
    for (int p = 0; p < RAND_PHASES; p++) begin
      lim = (phase_limit[p] < 0) ? $urandom_range(0, 127) : phase_limit[p];
      write_limit(lim);
      // idle pattern rotates: none, light, heavy; the last phase runs flat out
      idle_pct = (p == RAND_PHASES - 1) ? 0 : (p % 3) * 30;
      clear_pct = (lim >= 32) ? 3 : 15;
      cluster_base = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(1, 100) <= clear_pct) queue_clear($urandom());
        else queue_add(pick_value());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() > 0) begin
      $display("%0t: %0d results never arrived, expected %h, actual none",
               $time, results_due.size(), results_due[0]);
      mismatches++;
    end

    $display("Covered %0d items over %0d limit settings; %0d results checked.",
             items_taken, RAND_PHASES + 4, results_seen);
    $display("Inserted %0d, rejected full %0d, cleared %0d; largest set held %0d.",
             n_inserted, n_full, n_cleared, peak_count);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
